// ===== design/assert_macros.svh =====
// Assertion macros used by the length feed target controller core.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lftc_pkg.sv =====
// Shared constants, types and helper functions of the length feed target controller.
// No dependencies; lftc_csr, lftc_dist and the core refer to it by scoped names.
package lftc_pkg;

   localparam int SPEED_LEVELS = 3;
   localparam int LEVEL_W      = $clog2(SPEED_LEVELS);
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(SPEED_LEVELS - 1);

   localparam int DIST_FIELD_W  = 16;
   localparam int SPEED_FIELD_W = 8;

   // per-edge step is calibration times this many micrometres
   localparam int EDGE_UNIT = 3;
   localparam int MAG_W     = 10;
   localparam logic signed [31:0] VOLUME_MIN_UM = 32'sd80000;

   // x / 1000 == ((x >> 3) * RECIP_M) >> RECIP_SHIFT for any 32-bit x
   localparam int RECIP_PRE_SHIFT = 3;
   localparam int RECIP_SHIFT     = 36;
   localparam logic [29:0] RECIP_M = 30'd549755814;
   localparam int DIST_MAG_W = 23;
   localparam int DIST_W     = 24;

   // configuration port
   localparam int ADDR_W    = 6;
   localparam int DATA_W    = 64;
   localparam int REG_IDX_W = 3;
   localparam int REG_LSB   = 3;

   localparam logic [REG_IDX_W-1:0] REG_LENGTH_CALIBRATION   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DIRECTION_INVERT     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SERIES_INVERT        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_VALVE_OPEN_TIME_MS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VALVE_CLOSED_TIME_MS = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_LENGTH_UM     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_DISTANCES      = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_SPEEDS         = 3'd7;

   localparam logic [7:0]  RST_LENGTH_CALIBRATION   = 8'd66;
   localparam logic        RST_DIRECTION_INVERT     = 1'b1;
   localparam logic        RST_SERIES_INVERT        = 1'b0;
   localparam logic [15:0] RST_VALVE_OPEN_TIME_MS   = 16'd60;
   localparam logic [15:0] RST_VALVE_CLOSED_TIME_MS = 16'd1000;
   localparam logic [30:0] RST_TARGET_LENGTH_UM     = 31'd3000000;
   localparam logic [47:0] RST_LEVEL_DISTANCES      = 48'd21475492340;
   localparam logic [23:0] RST_LEVEL_SPEEDS         = 24'd2313060;
   localparam logic signed [DIST_W-1:0] RST_DISTANCE_MM = 24'sd3000;

   // item function codes
   localparam logic [1:0] FUNC_EDGE_ONE = 2'd0;
   localparam logic [1:0] FUNC_EDGE_TWO = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;
   localparam logic [1:0] FUNC_CLEAR    = 2'd3;

   // feed mode codes
   localparam logic [2:0] MODE_OFF      = 3'd0;
   localparam logic [2:0] MODE_APPROACH = 3'd1;
   localparam logic [2:0] MODE_MANUAL   = 3'd2;
   localparam logic [2:0] MODE_REACHED  = 3'd3;
   localparam logic [2:0] MODE_LOST     = 3'd4;

   // motion codes
   localparam logic [1:0] MOTION_NONE  = 2'd0;
   localparam logic [1:0] MOTION_FWD   = 2'd1;
   localparam logic [1:0] MOTION_BACK  = 2'd2;
   localparam logic [1:0] MOTION_STUCK = 2'd3;

   // valve command codes
   localparam logic [1:0] VALVE_NONE  = 2'd0;
   localparam logic [1:0] VALVE_CLOSE = 2'd1;
   localparam logic [1:0] VALVE_OPEN  = 2'd2;

   typedef struct packed {
      logic [7:0]  length_calibration;
      logic        direction_invert;
      logic        series_invert;
      logic [15:0] valve_open_time_ms;
      logic [15:0] valve_closed_time_ms;
      logic [30:0] target_length_um;
      logic [47:0] level_distances;
      logic [23:0] level_speeds;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        func;
      logic              line_one;
      logic              line_two;
      logic              saw_home;
      logic signed [7:0] operator_request;
      logic              request_pressed;
      logic              parallel_mode;
      logic [15:0]       tick_ms;
   } req_type;

   typedef struct packed {
      logic signed [7:0]        drive_request;
      logic                     series_on;
      logic [1:0]               valve_command;
      logic [2:0]               mode;
      logic [1:0]               motion;
      logic signed [DIST_W-1:0] distance_to_target_mm;
      logic signed [31:0]       length_now_um;
      logic                     volume_logged;
   } rsp_type;

   function automatic logic [DIST_FIELD_W-1:0] level_dist(
      input logic [47:0]        dists,
      input logic [LEVEL_W-1:0] idx
   );
      logic [63:0] w;
      w = 64'(dists) >> (DIST_FIELD_W * int'(idx));
      return w[DIST_FIELD_W-1:0];
   endfunction

   // speed magnitude saturated to 127
   function automatic logic [6:0] level_speed(
      input logic [23:0]        speeds,
      input logic [LEVEL_W-1:0] idx
   );
      logic [31:0] w;
      w = 32'(speeds) >> (SPEED_FIELD_W * int'(idx));
      return w[7] ? 7'd127 : w[6:0];
   endfunction

endpackage

// ===== design/lftc_if.sv =====
// Handshake channels of the length feed target controller: request items and result items.
// Valid/ready handshake; no dependencies.
interface lftc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic              line_one;
   logic              line_two;
   logic              saw_home;
   logic signed [7:0] operator_request;
   logic              request_pressed;
   logic              parallel_mode;
   logic [15:0]       tick_ms;

   modport source (
      output valid, func, line_one, line_two, saw_home, operator_request,
             request_pressed, parallel_mode, tick_ms,
      input  ready
   );
   modport sink (
      input  valid, func, line_one, line_two, saw_home, operator_request,
             request_pressed, parallel_mode, tick_ms,
      output ready
   );
endinterface

interface lftc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [7:0]  drive_request;
   logic               series_on;
   logic [1:0]         valve_command;
   logic [2:0]         mode;
   logic [1:0]         motion;
   logic signed [23:0] distance_to_target_mm;
   logic signed [31:0] length_now_um;
   logic               volume_logged;

   modport source (
      output valid, drive_request, series_on, valve_command, mode, motion,
             distance_to_target_mm, length_now_um, volume_logged,
      input  ready
   );
   modport sink (
      input  valid, drive_request, series_on, valve_command, mode, motion,
             distance_to_target_mm, length_now_um, volume_logged,
      output ready
   );
endinterface

// ===== design/lftc_csr.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on lftc_pkg for register indexes, reset values and cfg_type.
module lftc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lftc_pkg::ADDR_W-1:0]  paddr,
   input  logic [lftc_pkg::DATA_W-1:0]  pwdata,
   output logic [lftc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output lftc_pkg::cfg_type            cfg
);

   lftc_pkg::cfg_type               cfg_ff;
   logic [lftc_pkg::REG_IDX_W-1:0]  reg_idx;
   logic                            wr_en;

   assign reg_idx = paddr[lftc_pkg::ADDR_W-1:lftc_pkg::REG_LSB];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_calibration   <= lftc_pkg::RST_LENGTH_CALIBRATION;
         cfg_ff.direction_invert     <= lftc_pkg::RST_DIRECTION_INVERT;
         cfg_ff.series_invert        <= lftc_pkg::RST_SERIES_INVERT;
         cfg_ff.valve_open_time_ms   <= lftc_pkg::RST_VALVE_OPEN_TIME_MS;
         cfg_ff.valve_closed_time_ms <= lftc_pkg::RST_VALVE_CLOSED_TIME_MS;
         cfg_ff.target_length_um     <= lftc_pkg::RST_TARGET_LENGTH_UM;
         cfg_ff.level_distances      <= lftc_pkg::RST_LEVEL_DISTANCES;
         cfg_ff.level_speeds         <= lftc_pkg::RST_LEVEL_SPEEDS;
      end else if (wr_en) begin
         unique case (reg_idx)
            lftc_pkg::REG_LENGTH_CALIBRATION: begin
               cfg_ff.length_calibration <= pwdata[7:0];
            end
            lftc_pkg::REG_DIRECTION_INVERT: begin
               cfg_ff.direction_invert <= pwdata[0];
            end
            lftc_pkg::REG_SERIES_INVERT: begin
               cfg_ff.series_invert <= pwdata[0];
            end
            lftc_pkg::REG_VALVE_OPEN_TIME_MS: begin
               cfg_ff.valve_open_time_ms <= pwdata[15:0];
            end
            lftc_pkg::REG_VALVE_CLOSED_TIME_MS: begin
               cfg_ff.valve_closed_time_ms <= pwdata[15:0];
            end
            lftc_pkg::REG_TARGET_LENGTH_UM: begin
               cfg_ff.target_length_um <= pwdata[30:0];
            end
            lftc_pkg::REG_LEVEL_DISTANCES: begin
               cfg_ff.level_distances <= pwdata[47:0];
            end
            lftc_pkg::REG_LEVEL_SPEEDS: begin
               cfg_ff.level_speeds <= pwdata[23:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         lftc_pkg::REG_LENGTH_CALIBRATION:   prdata = 64'(cfg_ff.length_calibration);
         lftc_pkg::REG_DIRECTION_INVERT:     prdata = 64'(cfg_ff.direction_invert);
         lftc_pkg::REG_SERIES_INVERT:        prdata = 64'(cfg_ff.series_invert);
         lftc_pkg::REG_VALVE_OPEN_TIME_MS:   prdata = 64'(cfg_ff.valve_open_time_ms);
         lftc_pkg::REG_VALVE_CLOSED_TIME_MS: prdata = 64'(cfg_ff.valve_closed_time_ms);
         lftc_pkg::REG_TARGET_LENGTH_UM:     prdata = 64'(cfg_ff.target_length_um);
         lftc_pkg::REG_LEVEL_DISTANCES:      prdata = 64'(cfg_ff.level_distances);
         lftc_pkg::REG_LEVEL_SPEEDS:         prdata = 64'(cfg_ff.level_speeds);
      endcase
   end

endmodule

// ===== design/lftc_dist.sv =====
// Distance to target in mm, truncated toward zero, from target and signed length.
// Divides by 1000 with a reciprocal multiply; depends on lftc_pkg.
module lftc_dist (
   input  logic [30:0]                              target_length_um,
   input  logic signed [31:0]                       length_um,
   output logic signed [lftc_pkg::DIST_W-1:0]       dist_mm,
   output logic [lftc_pkg::DIST_MAG_W-1:0]          dist_abs_mm,
   output logic                                     dist_neg
);

   logic signed [32:0] diff;
   logic [32:0]        diff_neg;
   logic [31:0]        diff_abs;
   logic [28:0]        pre;
   logic [58:0]        prod;
   logic [lftc_pkg::DIST_MAG_W-1:0] quo;

   always_comb begin
      diff     = $signed({2'b00, target_length_um}) - $signed({length_um[31], length_um});
      diff_neg = 33'(-diff);
      diff_abs = diff[32] ? diff_neg[31:0] : diff[31:0];
      pre      = diff_abs[31:lftc_pkg::RECIP_PRE_SHIFT];
      prod     = 59'(pre) * 59'(lftc_pkg::RECIP_M);
      quo      = prod[lftc_pkg::RECIP_SHIFT +: lftc_pkg::DIST_MAG_W];
   end

   assign dist_abs_mm = quo;
   assign dist_neg    = diff[32] && (quo != '0);
   assign dist_mm     = diff[32] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ===== design/length_feed_target_controller_core.sv =====
// Length feed target controller: encoder length counter, feed mode machine and valve timer.
// Depends on lftc_pkg, lftc_if.sv, lftc_csr, lftc_dist and assert_macros.svh.
//
// Every request item yields exactly one result item. The block takes one item per clock
// cycle while the result side is not stalled; an accepted item is held in the input
// register and passes through the control logic into the result register when that
// register is empty or being read. The length, mode and valve state are updated in a
// single step per item, reading the state left by the previous item. Configuration writes
// go through the APB port at byte address 8*index and are meant for idle periods only.
`include "assert_macros.svh"

module length_feed_target_controller_core (
   input  logic                        clock,
   input  logic                        reset,
   lftc_req_if.sink                    req_ch,
   lftc_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lftc_pkg::ADDR_W-1:0] paddr,
   input  logic [lftc_pkg::DATA_W-1:0] pwdata,
   output logic [lftc_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   lftc_pkg::cfg_type cfg;

   // input stage
   logic              in_valid_ff;
   lftc_pkg::req_type in_ff;
   lftc_pkg::req_type req_item;

   // result stage
   logic              out_valid_ff;
   lftc_pkg::rsp_type out_ff;
   lftc_pkg::rsp_type out_in;

   // controller state
   logic signed [31:0]                      length_ff, length_in;
   logic signed [31:0]                      prev_length_ff, prev_length_in;
   logic [2:0]                              mode_ff, mode_in;
   logic [lftc_pkg::LEVEL_W-1:0]            level_ff, level_in;
   logic                                    valve_open_ff, valve_open_in;
   logic [15:0]                             valve_timer_ff, valve_timer_in;
   logic [1:0]                              motion_ff, motion_in;
   logic signed [lftc_pkg::DIST_W-1:0]      dist_ff, dist_in;

   logic                                    advance;

   logic signed [lftc_pkg::DIST_W-1:0]      dist_mm;
   logic [lftc_pkg::DIST_MAG_W-1:0]         dist_abs_mm;
   logic                                    dist_neg;
   logic                                    dist_pos;

   logic [lftc_pkg::MAG_W-1:0]              step_mag;
   logic                                    step_add;
   logic                                    oper_nz;
   logic                                    oper_pos;
   logic [lftc_pkg::LEVEL_W:0]              lvl_w;
   logic [6:0]                              spd;
   logic signed [7:0]                       drive;
   logic                                    series;
   logic [1:0]                              valve_cmd;
   logic                                    logged;

   lftc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lftc_dist u_dist (
      .target_length_um (cfg.target_length_um),
      .length_um        (length_ff),
      .dist_mm          (dist_mm),
      .dist_abs_mm      (dist_abs_mm),
      .dist_neg         (dist_neg)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      req_item.func             = req_ch.func;
      req_item.line_one         = req_ch.line_one;
      req_item.line_two         = req_ch.line_two;
      req_item.saw_home         = req_ch.saw_home;
      req_item.operator_request = req_ch.operator_request;
      req_item.request_pressed  = req_ch.request_pressed;
      req_item.parallel_mode    = req_ch.parallel_mode;
      req_item.tick_ms          = req_ch.tick_ms;
   end

   always_comb begin
      length_in      = length_ff;
      prev_length_in = prev_length_ff;
      mode_in        = mode_ff;
      lvl_w          = {1'b0, level_ff};
      valve_open_in  = valve_open_ff;
      valve_timer_in = valve_timer_ff;
      motion_in      = motion_ff;
      dist_in        = dist_ff;
      drive          = '0;
      series         = 1'b0;
      valve_cmd      = lftc_pkg::VALVE_NONE;
      logged         = 1'b0;
      spd            = '0;

      step_mag = lftc_pkg::MAG_W'(cfg.length_calibration) *
                 lftc_pkg::MAG_W'(lftc_pkg::EDGE_UNIT);
      step_add = (in_ff.line_one == in_ff.line_two) ^ cfg.direction_invert ^
                 (in_ff.func == lftc_pkg::FUNC_EDGE_TWO);
      oper_nz  = (in_ff.operator_request != '0);
      oper_pos = oper_nz && !in_ff.operator_request[7];
      dist_pos = !dist_neg && (dist_abs_mm != '0);

      unique case (in_ff.func)
         lftc_pkg::FUNC_EDGE_ONE, lftc_pkg::FUNC_EDGE_TWO: begin
            length_in = step_add ? length_ff + 32'(step_mag) : length_ff - 32'(step_mag);
         end
         lftc_pkg::FUNC_CLEAR: begin
            logged    = (length_ff > lftc_pkg::VOLUME_MIN_UM);
            length_in = '0;
         end
         lftc_pkg::FUNC_TICK: begin
            dist_in = dist_mm;
            if (!in_ff.saw_home) begin
               motion_in = lftc_pkg::MOTION_NONE;
            end else begin
               drive = in_ff.operator_request;
               if (!oper_nz) begin
                  motion_in = lftc_pkg::MOTION_NONE;
               end else if (length_ff > prev_length_ff) begin
                  motion_in = lftc_pkg::MOTION_FWD;
               end else if (length_ff < prev_length_ff) begin
                  motion_in = lftc_pkg::MOTION_BACK;
               end else begin
                  motion_in = lftc_pkg::MOTION_STUCK;
               end

               if (!oper_nz) begin
                  if (mode_ff != lftc_pkg::MODE_REACHED && mode_ff != lftc_pkg::MODE_LOST) begin
                     mode_in = lftc_pkg::MODE_OFF;
                  end
               end else begin
                  if (in_ff.request_pressed) begin
                     if ((dist_abs_mm < lftc_pkg::DIST_MAG_W'(lftc_pkg::level_dist(
                             cfg.level_distances, lftc_pkg::LEVEL_TOP))) ||
                         (dist_neg && oper_pos) ||
                         (dist_pos && in_ff.operator_request[7])) begin
                        mode_in = lftc_pkg::MODE_MANUAL;
                     end else begin
                        mode_in = lftc_pkg::MODE_APPROACH;
                        lvl_w   = '0;
                     end
                  end
                  if (mode_in == lftc_pkg::MODE_APPROACH) begin
                     if (dist_abs_mm < lftc_pkg::DIST_MAG_W'(lftc_pkg::level_dist(
                            cfg.level_distances, lvl_w[lftc_pkg::LEVEL_W-1:0]))) begin
                        lvl_w = lvl_w + 1'b1;
                        // past the last level: hold it and mark the target reached
                        if (lvl_w >= (lftc_pkg::LEVEL_W + 1)'(lftc_pkg::SPEED_LEVELS)) begin
                           lvl_w   = {1'b0, lftc_pkg::LEVEL_TOP};
                           mode_in = lftc_pkg::MODE_REACHED;
                        end
                     end else if ((lvl_w != '0) &&
                                  (dist_abs_mm > lftc_pkg::DIST_MAG_W'(lftc_pkg::level_dist(
                                     cfg.level_distances,
                                     lftc_pkg::LEVEL_W'(lvl_w - 1'b1))))) begin
                        lvl_w = lvl_w - 1'b1;
                     end
                     spd   = lftc_pkg::level_speed(cfg.level_speeds,
                                                   lvl_w[lftc_pkg::LEVEL_W-1:0]);
                     drive = dist_neg ? -$signed({1'b0, spd}) : $signed({1'b0, spd});
                  end else if (mode_in != lftc_pkg::MODE_MANUAL) begin
                     drive = '0;
                  end
               end

               if (drive != '0) begin
                  if (cfg.valve_open_time_ms == '0) begin
                     valve_open_in = 1'b0;
                  end else if (valve_timer_ff <= in_ff.tick_ms) begin
                     valve_open_in  = !valve_open_ff;
                     valve_timer_in = valve_open_ff ? cfg.valve_closed_time_ms
                                                    : cfg.valve_open_time_ms;
                  end else begin
                     valve_timer_in = valve_timer_ff - in_ff.tick_ms;
                  end
                  valve_cmd = valve_open_in ? lftc_pkg::VALVE_OPEN : lftc_pkg::VALVE_CLOSE;
               end else begin
                  valve_cmd      = valve_open_ff ? lftc_pkg::VALVE_CLOSE : lftc_pkg::VALVE_NONE;
                  valve_open_in  = 1'b0;
                  valve_timer_in = cfg.valve_open_time_ms;
               end
            end
            prev_length_in = length_ff;
            series = (drive != '0) && ((!in_ff.parallel_mode) == cfg.series_invert);
         end
      endcase

      level_in = lvl_w[lftc_pkg::LEVEL_W-1:0];

      out_in.drive_request         = drive;
      out_in.series_on             = series;
      out_in.valve_command         = valve_cmd;
      out_in.mode                  = mode_in;
      out_in.motion                = motion_in;
      out_in.distance_to_target_mm = dist_in;
      out_in.length_now_um         = length_in;
      out_in.volume_logged         = logged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         length_ff      <= '0;
         prev_length_ff <= '0;
         mode_ff        <= lftc_pkg::MODE_OFF;
         level_ff       <= '0;
         valve_open_ff  <= 1'b1;
         valve_timer_ff <= lftc_pkg::RST_VALVE_OPEN_TIME_MS;
         motion_ff      <= lftc_pkg::MOTION_NONE;
         dist_ff        <= lftc_pkg::RST_DISTANCE_MM;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff   <= 1'b1;
            length_ff      <= length_in;
            prev_length_ff <= prev_length_in;
            mode_ff        <= mode_in;
            level_ff       <= level_in;
            valve_open_ff  <= valve_open_in;
            valve_timer_ff <= valve_timer_in;
            motion_ff      <= motion_in;
            dist_ff        <= dist_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: load on acceptance only
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff <= req_item;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid                 = out_valid_ff;
   assign rsp_ch.drive_request         = out_ff.drive_request;
   assign rsp_ch.series_on             = out_ff.series_on;
   assign rsp_ch.valve_command         = out_ff.valve_command;
   assign rsp_ch.mode                  = out_ff.mode;
   assign rsp_ch.motion                = out_ff.motion;
   assign rsp_ch.distance_to_target_mm = out_ff.distance_to_target_mm;
   assign rsp_ch.length_now_um         = out_ff.length_now_um;
   assign rsp_ch.volume_logged         = out_ff.volume_logged;

   `ASSERT_ALWAYS(a_level_range, clock, reset, level_ff <= lftc_pkg::LEVEL_TOP)
   `ASSERT_IMPLY(a_reached_top_level, clock, reset,
      mode_ff == lftc_pkg::MODE_REACHED, level_ff == lftc_pkg::LEVEL_TOP)
   `ASSERT_IMPLY(a_series_needs_drive, clock, reset,
      rsp_ch.valid && rsp_ch.drive_request == 8'sd0, !rsp_ch.series_on)
   `ASSERT_IMPLY(a_open_needs_drive, clock, reset,
      rsp_ch.valid && rsp_ch.valve_command == lftc_pkg::VALVE_OPEN,
      rsp_ch.drive_request != 8'sd0)
   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_ch.valid && req_ch.ready, in_valid_ff)

endmodule
